@@ src/dvp_pa_pkg.sv @@
package dvp_pa_pkg;

    localparam int DEF_MAX_WIDTH  = 640;
    localparam int DEF_MAX_HEIGHT = 480;

    localparam int WORD_W  = 32;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int IDX_W   = 19;
    localparam int PIX_W   = 16;
    localparam int BYTE_W  = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_FRAME_WIDTH  = 2'd0;
    localparam cfg_idx_t CFG_FRAME_HEIGHT = 2'd1;
    localparam cfg_idx_t CFG_HREF_MASK    = 2'd2;

    localparam logic [COL_W-1:0]  RST_FRAME_WIDTH  = 10'd320;
    localparam logic [ROW_W-1:0]  RST_FRAME_HEIGHT = 9'd240;

endpackage

@@ src/camera_dvp_pixel_assembler_top.sv @@
// Camera DVP pixel assembler.
// Input channel (s_valid/s_ready, s_sample_word): one sampled port word per
// camera pixel clock edge. The line-valid bit is any bit of the word under
// href_mask; while it is high a data byte is gathered from port bits 18-19
// and 22-27, and byte pairs form 16-bit pixels, first byte low.
// Result channel (m_valid/m_ready): exactly one result per input transfer,
// carrying a buffer write strobe with buffer, word index and pixel, plus a
// frame-done flag naming the ping-pong buffer just completed.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): writes
// frame_width, frame_height and href_mask; always ready, write only while idle.
// Registered output: the result of a transfer shows on the m_ ports in the
// next cycle. Throughput is one sample per cycle, set by the single output
// register; s_ready stays high while the output register is empty or being
// taken in the same cycle.
// When the receiver stalls, the result holds and s_ready drops until it is
// taken. Reset clears all counters, selects buffer 0, drops any pending half
// pixel and loads width 320, height 240 and an all-zero href_mask.
module camera_dvp_pixel_assembler_top #(
    parameter int MAX_WIDTH  = dvp_pa_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dvp_pa_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [dvp_pa_pkg::WORD_W-1:0]     s_sample_word,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_write_enable,
    output logic                              m_write_buffer,
    output logic [dvp_pa_pkg::IDX_W-1:0]      m_write_index,
    output logic [dvp_pa_pkg::PIX_W-1:0]      m_pixel_value,
    output logic                              m_frame_done,
    output logic                              m_done_buffer,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dvp_pa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dvp_pa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dvp_pa_pkg::*;

    localparam int W_CLIP = (MAX_WIDTH > 1023) ? 1023 : MAX_WIDTH;
    localparam int H_CLIP = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
    localparam logic [COL_W-1:0] W_LIMIT = COL_W'(W_CLIP);
    localparam logic [ROW_W-1:0] H_LIMIT = ROW_W'(H_CLIP);

    logic [COL_W-1:0]  frame_width_reg;
    logic [ROW_W-1:0]  frame_height_reg;
    logic [WORD_W-1:0] href_mask_reg;

    logic [BYTE_W-1:0] pending_byte_reg, pending_byte_next;
    logic              pending_valid_reg, pending_valid_next;
    logic [COL_W-1:0]  column_count_reg, column_count_next;
    logic [ROW_W-1:0]  row_count_reg, row_count_next;
    logic [IDX_W-1:0]  row_base_reg, row_base_next;
    logic [IDX_W-1:0]  write_offset_reg, write_offset_next;
    logic              active_buffer_reg, active_buffer_next;

    logic              m_valid_reg;
    logic              we_reg, we_next;
    logic              wb_reg, wb_next;
    logic [IDX_W-1:0]  wi_reg, wi_next;
    logic [PIX_W-1:0]  pv_reg, pv_next;
    logic              fd_reg, fd_next;
    logic              db_reg, db_next;

    logic [COL_W-1:0]  width_eff;
    logic [ROW_W-1:0]  height_eff;
    logic              line_valid;
    logic [BYTE_W-1:0] data_byte;
    logic [COL_W-1:0]  col_inc;
    logic [ROW_W-1:0]  row_inc;
    logic [IDX_W-1:0]  base_inc;
    logic              s_xfer;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign width_eff  = (frame_width_reg == '0) ? COL_W'(1) :
                        (frame_width_reg > W_LIMIT) ? W_LIMIT : frame_width_reg;
    assign height_eff = (frame_height_reg == '0) ? ROW_W'(1) :
                        (frame_height_reg > H_LIMIT) ? H_LIMIT : frame_height_reg;

    assign line_valid = |(s_sample_word & href_mask_reg);
    assign data_byte  = {s_sample_word[27:22], s_sample_word[19:18]};
    assign col_inc    = column_count_reg + COL_W'(1);
    assign row_inc    = row_count_reg + ROW_W'(1);
    assign base_inc   = row_base_reg + IDX_W'(width_eff);

    always_comb begin
        pending_byte_next  = pending_byte_reg;
        pending_valid_next = pending_valid_reg;
        column_count_next  = column_count_reg;
        row_count_next     = row_count_reg;
        row_base_next      = row_base_reg;
        write_offset_next  = write_offset_reg;
        active_buffer_next = active_buffer_reg;
        we_next = 1'b0;
        wb_next = 1'b0;
        wi_next = '0;
        pv_next = '0;
        fd_next = 1'b0;
        db_next = 1'b0;

        if (line_valid) begin
            if (pending_valid_reg) begin
                we_next            = 1'b1;
                wb_next            = active_buffer_reg;
                wi_next            = write_offset_reg;
                pv_next            = {data_byte, pending_byte_reg};
                write_offset_next  = write_offset_reg + IDX_W'(1);
                column_count_next  = col_inc;
                pending_valid_next = 1'b0;
                pending_byte_next  = '0;
                if (col_inc == width_eff) begin
                    row_count_next    = row_inc;
                    column_count_next = '0;
                    row_base_next     = base_inc;
                end
            end else begin
                pending_byte_next  = data_byte;
                pending_valid_next = 1'b1;
            end
        end else if (column_count_reg != '0) begin
            // line ended early: move to the next row, drop the half pixel
            row_count_next     = row_inc;
            column_count_next  = '0;
            row_base_next      = base_inc;
            write_offset_next  = base_inc;
            pending_valid_next = 1'b0;
            pending_byte_next  = '0;
        end

        if (row_count_next == height_eff) begin
            row_count_next     = '0;
            fd_next            = 1'b1;
            db_next            = active_buffer_reg;
            active_buffer_next = !active_buffer_reg;
            row_base_next      = '0;
            write_offset_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            href_mask_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[COL_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[ROW_W-1:0];
                CFG_HREF_MASK:    href_mask_reg    <= cfg_data[WORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_byte_reg  <= '0;
            pending_valid_reg <= 1'b0;
            column_count_reg  <= '0;
            row_count_reg     <= '0;
            row_base_reg      <= '0;
            write_offset_reg  <= '0;
            active_buffer_reg <= 1'b0;
        end else if (s_xfer) begin
            pending_byte_reg  <= pending_byte_next;
            pending_valid_reg <= pending_valid_next;
            column_count_reg  <= column_count_next;
            row_count_reg     <= row_count_next;
            row_base_reg      <= row_base_next;
            write_offset_reg  <= write_offset_next;
            active_buffer_reg <= active_buffer_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            we_reg <= we_next;
            wb_reg <= wb_next;
            wi_reg <= wi_next;
            pv_reg <= pv_next;
            fd_reg <= fd_next;
            db_reg <= db_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_write_enable = we_reg;
    assign m_write_buffer = wb_reg;
    assign m_write_index  = wi_reg;
    assign m_pixel_value  = pv_reg;
    assign m_frame_done   = fd_reg;
    assign m_done_buffer  = db_reg;

endmodule

@@ src/dvp_pa_checker.sv @@
module dvp_pa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_write_enable,
    input logic                          m_write_buffer,
    input logic [dvp_pa_pkg::IDX_W-1:0]  m_write_index,
    input logic [dvp_pa_pkg::PIX_W-1:0]  m_pixel_value,
    input logic                          m_frame_done,
    input logic                          m_done_buffer
);
    import dvp_pa_pkg::*;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (s_ready && !m_valid))
        else $error("output not empty after reset");

    a_empty_ready: assert property (@(posedge aclk)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_write_index)
                                   && $stable(m_pixel_value)))
        else $error("stalled result changed");

    a_idle_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_write_enable) |-> (m_write_index == '0
            && m_pixel_value == '0 && !m_write_buffer))
        else $error("write fields nonzero without write strobe");

    a_done_buffer_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_done) |-> !m_done_buffer)
        else $error("done buffer set without frame done");

endmodule

bind camera_dvp_pixel_assembler_top dvp_pa_checker u_dvp_pa_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_write_enable (m_write_enable),
    .m_write_buffer (m_write_buffer),
    .m_write_index  (m_write_index),
    .m_pixel_value  (m_pixel_value),
    .m_frame_done   (m_frame_done),
    .m_done_buffer  (m_done_buffer)
);

@@ tb/sv/pixel_write_checker.sv @@
`timescale 1ns / 100ps

module pixel_write_checker #(
    parameter int MAX_WIDTH  = dvp_pa_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dvp_pa_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [dvp_pa_pkg::WORD_W-1:0]     s_sample_word,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              m_write_enable,
    input  logic                              m_write_buffer,
    input  logic [dvp_pa_pkg::IDX_W-1:0]      m_write_index,
    input  logic [dvp_pa_pkg::PIX_W-1:0]      m_pixel_value,
    input  logic                              m_frame_done,
    input  logic                              m_done_buffer,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  dvp_pa_pkg::cfg_idx_t              cfg_index,
    input  logic [dvp_pa_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                fail_count,
    output int                                n_expected,
    output int                                n_pixels,
    output int                                n_frames
);
    import dvp_pa_pkg::*;

    typedef struct packed {
        logic             write_enable;
        logic             write_buffer;
        logic [IDX_W-1:0] write_index;
        logic [PIX_W-1:0] pixel_value;
        logic             frame_done;
        logic             done_buffer;
    } pixel_result_t;

    pixel_result_t expected_writes[$];

    logic [COL_W-1:0]  width_reg;
    logic [ROW_W-1:0]  height_reg;
    logic [WORD_W-1:0] href_sel;

    logic [BYTE_W-1:0] held_byte;
    logic              held_valid;
    logic [COL_W-1:0]  col_cnt;
    logic [ROW_W-1:0]  row_cnt;
    logic [IDX_W-1:0]  row_start;
    logic [IDX_W-1:0]  next_index;
    logic              fill_buffer;

    function automatic pixel_result_t assemble_sample(input logic [WORD_W-1:0] w);
        pixel_result_t     r;
        int                eff_w;
        int                eff_h;
        logic [BYTE_W-1:0] b;
        r     = '0;
        eff_w = (width_reg == '0) ? 1 :
                ((int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
        eff_h = (height_reg == '0) ? 1 :
                ((int'(height_reg) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg));
        if ((w & href_sel) != '0) begin
            b = {w[27:22], w[19:18]};
            if (held_valid) begin
                r.write_enable = 1'b1;
                r.write_buffer = fill_buffer;
                r.write_index  = next_index;
                r.pixel_value  = {b, held_byte};
                next_index     = next_index + 1'b1;
                col_cnt        = col_cnt + 1'b1;
                held_valid     = 1'b0;
                held_byte      = '0;
                if (int'(col_cnt) == eff_w) begin
                    row_cnt   = row_cnt + 1'b1;
                    col_cnt   = '0;
                    row_start = row_start + IDX_W'(eff_w);
                end
            end else begin
                held_byte  = b;
                held_valid = 1'b1;
            end
        end else if (col_cnt != '0) begin
            // line dropped mid-row: close the row, drop any half pixel
            row_cnt    = row_cnt + 1'b1;
            col_cnt    = '0;
            row_start  = row_start + IDX_W'(eff_w);
            next_index = row_start;
            held_valid = 1'b0;
            held_byte  = '0;
        end
        if (int'(row_cnt) == eff_h) begin
            row_cnt       = '0;
            r.frame_done  = 1'b1;
            r.done_buffer = fill_buffer;
            fill_buffer   = ~fill_buffer;
            row_start     = '0;
            next_index    = '0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        n_expected = 0;
        n_pixels   = 0;
        n_frames   = 0;
    end

    always @(posedge aclk) begin : scoreboard
        pixel_result_t want;
        pixel_result_t got;
        if (!aresetn) begin
            width_reg   = RST_FRAME_WIDTH;
            height_reg  = RST_FRAME_HEIGHT;
            href_sel    = '0;
            held_byte   = '0;
            held_valid  = 1'b0;
            col_cnt     = '0;
            row_cnt     = '0;
            row_start   = '0;
            next_index  = '0;
            fill_buffer = 1'b0;
            expected_writes.delete();
            n_expected  = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_write_enable, m_write_buffer, m_write_index, m_pixel_value,
                       m_frame_done, m_done_buffer};
                if (got.write_enable) n_pixels++;
                if (got.frame_done) n_frames++;
                if (expected_writes.size() == 0) begin
                    $error("result with nothing expected: index 0x%0h pixel 0x%0h",
                           got.write_index, got.pixel_value);
                    fail_count++;
                end else begin
                    want = expected_writes.pop_front();
                    check_field("write_enable", want.write_enable, got.write_enable);
                    check_field("write_buffer", want.write_buffer, got.write_buffer);
                    check_field("write_index", want.write_index, got.write_index);
                    check_field("pixel_value", want.pixel_value, got.pixel_value);
                    check_field("frame_done", want.frame_done, got.frame_done);
                    check_field("done_buffer", want.done_buffer, got.done_buffer);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FRAME_WIDTH: begin
                        width_reg = cfg_data[COL_W-1:0];
                    end
                    CFG_FRAME_HEIGHT: begin
                        height_reg = cfg_data[ROW_W-1:0];
                    end
                    CFG_HREF_MASK: begin
                        href_sel = cfg_data[WORD_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) expected_writes.push_back(assemble_sample(s_sample_word));
            n_expected = expected_writes.size();
        end
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import dvp_pa_pkg::*;

    localparam int       RANDOM_ITEMS = 1950;
    localparam int       HOLD_CYCLES  = 300;
    localparam int       STALL_LIMIT  = 4000;
    localparam cfg_idx_t CFG_UNUSED   = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [WORD_W-1:0]     s_sample_word;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_write_enable;
    logic                  m_write_buffer;
    logic [IDX_W-1:0]      m_write_index;
    logic [PIX_W-1:0]      m_pixel_value;
    logic                  m_frame_done;
    logic                  m_done_buffer;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int          fail_count;
    int          n_expected;
    int          n_pixels;
    int          n_frames;
    int          n_sent;
    int          n_directed;
    int          n_cfgs;
    int          src_idle_pct;
    int          sink_idle_pct;
    int          quiet_cycles;
    bit          hold_off;
    logic [31:0] cur_mask;

    camera_dvp_pixel_assembler_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_word (s_sample_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_write_enable(m_write_enable),
        .m_write_buffer(m_write_buffer),
        .m_write_index (m_write_index),
        .m_pixel_value (m_pixel_value),
        .m_frame_done  (m_frame_done),
        .m_done_buffer (m_done_buffer),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    pixel_write_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_word (s_sample_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_write_enable(m_write_enable),
        .m_write_buffer(m_write_buffer),
        .m_write_index (m_write_index),
        .m_pixel_value (m_pixel_value),
        .m_frame_done  (m_frame_done),
        .m_done_buffer (m_done_buffer),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .n_expected    (n_expected),
        .n_pixels      (n_pixels),
        .n_frames      (n_frames)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("** camera_dvp_pixel_assembler_top: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function automatic logic [31:0] pixel_word(input bit line, input logic [7:0] data);
        logic [31:0] w;
        w        = $urandom;
        w[19:18] = data[1:0];
        w[27:22] = data[7:2];
        if (!line) w = w & ~cur_mask;
        else if ((w & cur_mask) == '0) w = w | (cur_mask & (~cur_mask + 1'b1));
        return w;
    endfunction

    task automatic put_sample(input logic [31:0] w);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_sample_word <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic put_byte(input logic [7:0] data);
        put_sample(pixel_word(1'b1, data));
    endtask

    task automatic put_blank();
        put_sample(pixel_word(1'b0, 8'($urandom)));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (n_expected != 0) @(negedge aclk);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_frame(input int w, input int h, input logic [31:0] mask);
        drain();
        // upper bits beyond each register's width are don't-care
        cfg_write(CFG_FRAME_WIDTH, (32'($urandom) << COL_W) | 32'(w));
        cfg_write(CFG_FRAME_HEIGHT, (32'($urandom) << ROW_W) | 32'(h));
        cfg_write(CFG_HREF_MASK, mask);
        cfg_valid <= 1'b0;
        cur_mask = mask;
        n_cfgs++;
    endtask

    function automatic logic [31:0] pick_mask();
        case ($urandom_range(7))
            0: return 32'h0000_0001;
            1: return 32'h8000_0000;
            2: return 32'h0020_0000;
            3: return 32'h0004_0000;
            4: return 32'hFFFF_FFFF;
            5: return 32'h1 << $urandom_range(31);
            6: return $urandom | 32'h0000_0100;
            default: return ($urandom_range(3) == 0) ? 32'h0 : 32'h0000_0400;
        endcase
    endfunction

    task automatic run_rows(input int budget, input int row_max, input int broken_pct,
                            input int blank_max, input int noise_pct);
        int start;
        int npix;
        int lead;
        int trail;
        int odd;
        start = n_sent;
        while (n_sent - start < budget) begin
            if ($urandom_range(99) < noise_pct) begin
                repeat ($urandom_range(1, 3)) put_sample($urandom);
            end
            if ($urandom_range(99) < broken_pct) begin
                npix  = $urandom_range(0, row_max);
                odd   = $urandom_range(1);
                trail = $urandom_range(1, blank_max + 1);
            end else begin
                npix  = row_max;
                odd   = 0;
                trail = $urandom_range(0, blank_max);
            end
            lead = $urandom_range(0, blank_max);
            repeat (lead) put_blank();
            repeat (2 * npix + odd) put_byte(8'($urandom));
            repeat (trail) put_blank();
        end
    endtask

    initial begin : stimulus
        int          phase;
        int          rnd_done;
        int          w;
        int          h;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_sample_word = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_FRAME_WIDTH;
        cfg_data      = '0;
        hold_off      = 1'b0;
        cur_mask      = '0;
        quiet_cycles  = 0;
        n_sent        = 0;
        n_cfgs        = 0;
        src_idle_pct  = 15;
        sink_idle_pct = 46;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        put_sample(32'hFFFF_FFFF);
        put_sample(32'h0000_0000);
        drain();
        cfg_write(CFG_UNUSED, $urandom);
        set_frame(2, 2, 32'h0000_0001);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_blank();
        // line low at row start keeps the held byte
        put_byte(8'hA5);
        put_blank();
        put_byte(8'h5A);
        // drop the half pixel at a mid-row line drop, closing the frame
        put_byte(8'h3C);
        put_blank();
        repeat (2) begin
            put_byte(8'hFF);
            put_byte(8'h00);
        end
        repeat (4) put_byte(8'($urandom));
        n_directed = n_sent;

        phase = 0;
        while (n_sent < n_directed + RANDOM_ITEMS) begin
            rnd_done = n_sent - n_directed;
            if (rnd_done < RANDOM_ITEMS / 3) begin
                src_idle_pct  = 15;
                sink_idle_pct = 46;
            end else if (rnd_done < 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct  = 46;
                sink_idle_pct = 15;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            case (phase)
                2: begin
                    set_frame(1, 511, 32'h0000_0020);
                    run_rows(960, 1, 0, 0, 0);
                end
                4: begin
                    set_frame(1023, 3, 32'h8000_0000);
                    run_rows(120, 12, 100, 3, 0);
                end
                6: begin
                    set_frame(640, 480, pick_mask());
                    run_rows(100, 20, 100, 2, 5);
                end
                7: begin
                    set_frame(0, 0, 32'hFFFF_FFFF);
                    run_rows(80, 1, 30, 2, 5);
                end
                default: begin
                    w = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
                    h = $urandom_range(1, 4);
                    set_frame(w, h, pick_mask());
                    if (phase == 1) hold_off = 1'b1;
                    run_rows($urandom_range(40, 160), w, 20, 3, 5);
                end
            endcase
            phase++;
        end

        drain();
        repeat (8) @(negedge aclk);
        $display("Sent %0d samples across %0d register settings (held-off output, drains).",
                 n_sent, n_cfgs);
        $display("Saw %0d pixel writes and %0d completed frames.", n_pixels, n_frames);
        if (fail_count == 0 && n_expected == 0) begin
            $display("** camera_dvp_pixel_assembler_top: PASSED **");
        end else begin
            $display("** camera_dvp_pixel_assembler_top: FAILED **");
        end
        $finish;
    end

endmodule
